[sv/qte_pkg.sv]
// qte_pkg: widths, constants, types and the arctangent table for the
// quaternion to euler angle pipeline. No dependencies.
`default_nettype none
package qte_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;
  localparam int CORDIC_N      = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

  localparam int IN_W    = 16;
  localparam int OUT_W   = 16;
  localparam int PROD_W  = 2 * IN_W;
  localparam int T_W     = 36;
  localparam int SQ_BITS = 29;
  localparam int RAD_W   = 2 * SQ_BITS;
  localparam int XY_W    = 40;
  localparam int Z_W     = 28;
  localparam int DEG_W   = 23;
  localparam int DP_W    = Z_W + DEG_W;
  localparam int LANES   = 3;

  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;

  localparam logic UNIT_RAD = 1'b0;
  localparam logic UNIT_DEG = 1'b1;

  localparam logic signed [T_W-1:0] ONE_Q28     = T_W'(64'sd268435456);
  localparam logic signed [T_W-1:0] NEG_ONE_Q28 = -ONE_Q28;
  localparam logic [RAD_W-1:0]      ONE_Q56     = RAD_W'(1) << 56;

  localparam logic signed [Z_W-1:0] HALF_PI = Z_W'(26353589);
  localparam logic signed [Z_W-1:0] PI_Q24  = Z_W'(52707179);
  localparam logic signed [Z_W-1:0] NEG_PI  = -PI_Q24;

  localparam logic signed [DEG_W-1:0] DEG_FACTOR = DEG_W'(3754939);

  localparam logic signed [Z_W-1:0]  RAD_ROUND = Z_W'(2048);
  localparam logic signed [DP_W-1:0] DEG_ROUND = DP_W'(64'sd8589934592);
  localparam logic signed [DP_W-1:0] OUT_MAX   = DP_W'(32767);
  localparam logic signed [DP_W-1:0] OUT_MIN   = -DP_W'(32768);

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_lane_t;

  typedef struct packed {
    logic [RAD_W-1:0]       rem;
    logic [SQ_BITS-1:0]     root;
    logic signed [T_W-1:0]  t0;
    logic signed [T_W-1:0]  t1;
    logic signed [T_W-1:0]  t2;
    logic signed [T_W-1:0]  t3;
    logic signed [T_W-1:0]  t4;
  } sqrt_stage_t;

  // round(atan(2^-i) * 2^24)
  function automatic logic signed [Z_W-1:0] atan_entry(input int i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:       v = Z_W'(13176795);
      1:       v = Z_W'(7778716);
      2:       v = Z_W'(4110060);
      3:       v = Z_W'(2086331);
      4:       v = Z_W'(1047214);
      5:       v = Z_W'(524117);
      6:       v = Z_W'(262123);
      7:       v = Z_W'(131069);
      8:       v = Z_W'(65536);
      9:       v = Z_W'(32768);
      10:      v = Z_W'(16384);
      11:      v = Z_W'(8192);
      12:      v = Z_W'(4096);
      13:      v = Z_W'(2048);
      14:      v = Z_W'(1024);
      15:      v = Z_W'(512);
      16:      v = Z_W'(256);
      17:      v = Z_W'(128);
      18:      v = Z_W'(64);
      19:      v = Z_W'(32);
      20:      v = Z_W'(16);
      21:      v = Z_W'(8);
      22:      v = Z_W'(4);
      23:      v = Z_W'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[sv/quaternion_to_euler_top.sv]
// quaternion_to_euler_top: pipelined quaternion to roll/pitch/yaw converter.
// Depends on qte_pkg.
`default_nettype none
// One quaternion is taken per clock and one result leaves per clock unless
// out_ready stalls the pipe. A request passes through, in order: a register
// each for the products, the terms and the pitch radicand, 29 square root
// stages (one root bit each), one quadrant stage, one stage per cordic
// iteration, one for clamp and degree scaling, one output register.
// The whole pipeline holds while a result waits on out_ready, so in_ready
// follows !out_valid || out_ready. angle_unit is written on the cfg channel,
// which is always ready; write it only while no request is in flight.
module quaternion_to_euler_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [qte_pkg::IN_W-1:0]   qw,
  input  logic signed [qte_pkg::IN_W-1:0]   qx,
  input  logic signed [qte_pkg::IN_W-1:0]   qy,
  input  logic signed [qte_pkg::IN_W-1:0]   qz,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [qte_pkg::OUT_W-1:0]  roll_angle,
  output logic signed [qte_pkg::OUT_W-1:0]  pitch_angle,
  output logic signed [qte_pkg::OUT_W-1:0]  yaw_angle,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              angle_unit
);
  import qte_pkg::*;

  function automatic cordic_lane_t prerot(input logic signed [XY_W-1:0] y,
                                          input logic signed [XY_W-1:0] x);
    cordic_lane_t r;
    r.x = x;
    r.y = y;
    r.z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        r.x = y;
        r.y = -x;
        r.z = HALF_PI;
      end else begin
        r.x = -y;
        r.y = x;
        r.z = -HALF_PI;
      end
    end
    return r;
  endfunction

  function automatic cordic_lane_t cordic_step(input cordic_lane_t a, input int i);
    cordic_lane_t r;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    xs = a.x >>> i;
    ys = a.y >>> i;
    r = a;
    if (a.y > 0) begin
      r.x = a.x + ys;
      r.y = a.y - xs;
      r.z = a.z + atan_entry(i);
    end else if (a.y < 0) begin
      r.x = a.x - ys;
      r.y = a.y + xs;
      r.z = a.z - atan_entry(i);
    end
    return r;
  endfunction

  function automatic logic signed [OUT_W-1:0] encode(input logic signed [Z_W-1:0] z,
                                                     input logic signed [DP_W-1:0] p,
                                                     input logic u);
    logic signed [DP_W-1:0] r;
    logic signed [Z_W-1:0]  zr;
    zr = (z + RAD_ROUND) >>> 12;
    if (u == UNIT_DEG) r = (p + DEG_ROUND) >>> 34;
    else               r = DP_W'(zr);
    if (r > OUT_MAX) r = OUT_MAX;
    if (r < OUT_MIN) r = OUT_MIN;
    return r[OUT_W-1:0];
  endfunction

  logic unit;
  logic adv;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit <= UNIT_RAD;
    end else if (cfg_valid) begin
      unit <= angle_unit;
    end
  end

  // products
  logic v1;
  logic signed [PROD_W-1:0] p_xy, p_wz, p_xz, p_wy, p_yz, p_wx, p_xx, p_yy, p_zz;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_xy <= qx * qy;
      p_wz <= qw * qz;
      p_xz <= qx * qz;
      p_wy <= qw * qy;
      p_yz <= qy * qz;
      p_wx <= qw * qx;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_zz <= qz * qz;
    end
  end

  // terms
  logic v2;
  logic signed [T_W-1:0] t0, t1, t2, t3, t4;
  logic signed [T_W-1:0] t0_next, t1_next, t2_raw, t2_next, t3_next, t4_next;

  always_comb begin
    t0_next = ONE_Q28 - ((T_W'(p_yy) + T_W'(p_zz)) <<< 1);
    t1_next = (T_W'(p_xy) + T_W'(p_wz)) <<< 1;
    t2_raw  = (T_W'(p_wy) - T_W'(p_xz)) <<< 1;
    t3_next = (T_W'(p_yz) + T_W'(p_wx)) <<< 1;
    t4_next = ONE_Q28 - ((T_W'(p_xx) + T_W'(p_yy)) <<< 1);
    t2_next = t2_raw;
    if (t2_raw > ONE_Q28)     t2_next = ONE_Q28;
    if (t2_raw < NEG_ONE_Q28) t2_next = NEG_ONE_Q28;
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t0 <= t0_next;
      t1 <= t1_next;
      t2 <= t2_next;
      t3 <= t3_next;
      t4 <= t4_next;
    end
  end

  // pitch radicand and square root stages
  sqrt_stage_t        sq_pipe [SQ_BITS+1];
  logic [SQ_BITS:0]   sq_v;
  logic signed [SQ_BITS-1:0] t2_short;
  logic signed [RAD_W-1:0]   t2_sq;

  assign t2_short = t2[SQ_BITS-1:0];
  assign t2_sq    = t2_short * t2_short;

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else if (adv) sq_v[0] <= v2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_pipe[0].rem  <= ONE_Q56 - RAD_W'(t2_sq);
      sq_pipe[0].root <= '0;
      sq_pipe[0].t0   <= t0;
      sq_pipe[0].t1   <= t1;
      sq_pipe[0].t2   <= t2;
      sq_pipe[0].t3   <= t3;
      sq_pipe[0].t4   <= t4;
    end
  end

  for (genvar j = 0; j < SQ_BITS; j++) begin : g_sqrt
    localparam int K = SQ_BITS - 1 - j;
    logic [RAD_W-1:0] trial;
    sqrt_stage_t      stage_next;

    // (root + 2^k)^2 - root^2
    assign trial = ((RAD_W'(sq_pipe[j].root) << 1) | (RAD_W'(1) << K)) << K;

    always_comb begin
      stage_next = sq_pipe[j];
      if (sq_pipe[j].rem >= trial) begin
        stage_next.rem  = sq_pipe[j].rem - trial;
        stage_next.root = sq_pipe[j].root | (SQ_BITS'(1) << K);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) sq_v[j+1] <= 1'b0;
      else if (adv) sq_v[j+1] <= sq_v[j];
    end

    always_ff @(posedge clk) begin
      if (adv) sq_pipe[j+1] <= stage_next;
    end
  end

  // quadrant stage and cordic stages, three lanes
  cordic_lane_t    cl [LANES][CORDIC_N+1];
  logic [CORDIC_N:0] cv;
  sqrt_stage_t     sq_last;

  assign sq_last = sq_pipe[SQ_BITS];

  always_ff @(posedge clk) begin
    if (rst) cv[0] <= 1'b0;
    else if (adv) cv[0] <= sq_v[SQ_BITS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cl[LANE_ROLL][0]  <= prerot(XY_W'(sq_last.t3), XY_W'(sq_last.t4));
      cl[LANE_PITCH][0] <= prerot(XY_W'(sq_last.t2),
                                  XY_W'($signed({1'b0, sq_last.root})));
      cl[LANE_YAW][0]   <= prerot(XY_W'(sq_last.t1), XY_W'(sq_last.t0));
    end
  end

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) cv[i+1] <= 1'b0;
      else if (adv) cv[i+1] <= cv[i];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      always_ff @(posedge clk) begin
        if (adv) cl[l][i+1] <= cordic_step(cl[l][i], i);
      end
    end
  end

  // clamp to [-pi, pi] and scale for degrees
  logic va;
  logic signed [Z_W-1:0]  za [LANES];
  logic signed [DP_W-1:0] pa [LANES];

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (adv) va <= cv[CORDIC_N];
  end

  for (genvar l = 0; l < LANES; l++) begin : g_scale
    logic signed [Z_W-1:0] zc;

    always_comb begin
      zc = cl[l][CORDIC_N].z;
      if (zc > PI_Q24) zc = PI_Q24;
      if (zc < NEG_PI) zc = NEG_PI;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        za[l] <= zc;
        pa[l] <= DP_W'(zc) * DP_W'(DEG_FACTOR);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= va;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      roll_angle  <= encode(za[LANE_ROLL], pa[LANE_ROLL], unit);
      pitch_angle <= encode(za[LANE_PITCH], pa[LANE_PITCH], unit);
      yaw_angle   <= encode(za[LANE_YAW], pa[LANE_YAW], unit);
    end
  end

endmodule
`default_nettype wire

[sv/qte_checker.sv]
// qte_checker: port-level assertions for quaternion_to_euler_top, and the
// bind that attaches them. No package dependency.
`default_nettype none
module qte_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] roll_angle,
  input logic signed [15:0] pitch_angle,
  input logic signed [15:0] yaw_angle
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable(roll_angle) && $stable(pitch_angle) && $stable(yaw_angle))
    else $error("result changed while stalled");

  // a stalled result freezes the whole pipe
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while output stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind quaternion_to_euler_top qte_checker u_qte_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .roll_angle  (roll_angle),
  .pitch_angle (pitch_angle),
  .yaw_angle   (yaw_angle)
);
`default_nettype wire

[tb/tb_quaternion_to_euler_top.sv]
// tb_quaternion_to_euler_top: self-checking testbench for the quaternion to euler pipeline.
// Depends on qte_pkg and quaternion_to_euler_top; predicts each result in fixed point.
`timescale 1ns / 1ps
module tb_quaternion_to_euler_top;
  import qte_pkg::*;

  typedef struct {
    logic signed [OUT_W-1:0] roll;
    logic signed [OUT_W-1:0] pitch;
    logic signed [OUT_W-1:0] yaw;
  } euler_t;

  localparam longint ATAN_Q24 [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2};
  localparam longint HALF_PI_Q24 = 26353589;
  localparam longint PI_Q24_L    = 52707179;
  localparam longint DEG_SCALE   = 3754939;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [IN_W-1:0] qw = '0, qx = '0, qy = '0, qz = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic signed [OUT_W-1:0] roll_angle, pitch_angle, yaw_angle;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic angle_unit = UNIT_RAD;

  euler_t angles_pending[$];
  logic   unit_sel = UNIT_RAD;
  int     err_cnt = 0;
  int     sent_cnt = 0;
  int     recv_cnt = 0;
  bit     tx_idle_en = 1'b1;
  bit     rx_idle_en = 1'b1;
  bit     hold_req = 1'b0;

  always #5 clk = ~clk;

  quaternion_to_euler_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .qw(qw), .qx(qx), .qy(qy), .qz(qz),
    .out_valid(out_valid), .out_ready(out_ready),
    .roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .angle_unit(angle_unit)
  );

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint ang, t, xs, ys;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    // fold the left half plane onto the right one
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; ang = HALF_PI_Q24;
      end else begin
        x = -y; y = t; ang = -HALF_PI_Q24;
      end
    end
    for (int i = 0; i < CORDIC_N; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; ang += ATAN_Q24[i];
      end else if (y < 0) begin
        x = x - ys; y = y + xs; ang -= ATAN_Q24[i];
      end else begin
        break;
      end
    end
    if (ang > PI_Q24_L) ang = PI_Q24_L;
    if (ang < -PI_Q24_L) ang = -PI_Q24_L;
    return ang;
  endfunction

  function automatic logic signed [OUT_W-1:0] scale_angle(longint a, logic unit);
    longint r;
    if (unit == UNIT_RAD) r = (a + 2048) >>> 12;
    else r = (a * DEG_SCALE + (64'sd1 <<< 33)) >>> 34;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[OUT_W-1:0];
  endfunction

  function automatic euler_t quat_to_euler(logic signed [IN_W-1:0] w, x, y, z, logic unit);
    longint lw, lx, ly, lz, t0, t1, t2, t3, t4, one;
    longint unsigned c;
    euler_t e;
    lw = w; lx = x; ly = y; lz = z;
    one = 64'sd1 <<< 28;
    t0 = one - 2 * (ly * ly + lz * lz);
    t1 = 2 * (lx * ly + lw * lz);
    t2 = -2 * (lx * lz - lw * ly);
    t3 = 2 * (ly * lz + lw * lx);
    t4 = one - 2 * (lx * lx + ly * ly);
    if (t2 > one) t2 = one;
    if (t2 < -one) t2 = -one;
    c = int_sqrt((64'd1 << 56) - longint'(t2 * t2));
    e.roll  = scale_angle(vector_angle(t3, t4), unit);
    e.pitch = scale_angle(vector_angle(t2, longint'(c)), unit);
    e.yaw   = scale_angle(vector_angle(t1, t0), unit);
    return e;
  endfunction

  task automatic send_quat(logic signed [IN_W-1:0] w, x, y, z);
    bit rdy;
    in_valid <= 1'b1;
    qw <= w; qx <= x; qy <= y; qz <= z;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    angles_pending.push_back(quat_to_euler(w, x, y, z, unit_sel));
    sent_cnt++;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (angles_pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_unit(logic u);
    bit rdy;
    wait_drained();
    cfg_valid <= 1'b1;
    angle_unit <= u;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    unit_sel = u;
    cfg_valid <= 1'b0;
  endtask

  task automatic rand_quat(output logic signed [IN_W-1:0] w, x, y, z);
    real a[4];
    real n;
    int k;
    k = $urandom_range(0, 9);
    if (k < 2) begin
      // raw noise over the whole 16-bit range
      w = IN_W'($urandom);
      x = IN_W'($urandom);
      y = IN_W'($urandom);
      z = IN_W'($urandom);
    end else begin
      for (int i = 0; i < 4; i++) a[i] = $urandom_range(0, 65535) / 32767.5 - 1.0;
      if (k == 2) begin
        // near gimbal lock: w and y close in magnitude
        a[2] = ($urandom_range(0, 1) ? a[0] : -a[0]);
        a[1] = a[1] * 0.01;
        a[3] = a[3] * 0.01;
      end
      n = $sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3]);
      if (n < 1.0e-6) n = 1.0;
      w = IN_W'($rtoi(a[0] / n * 16384.0));
      x = IN_W'($rtoi(a[1] / n * 16384.0));
      y = IN_W'($rtoi(a[2] / n * 16384.0));
      z = IN_W'($rtoi(a[3] / n * 16384.0));
      if (k == 3) w = w + $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
    end
  endtask

  task automatic test_directed();
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    send_quat(-16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
    send_quat(16'sd0, 16'sd0, 16'sd0, -16'sd16384);
    send_quat(16'sd11585, 16'sd0, 16'sd11585, 16'sd0);
    send_quat(16'sd11586, 16'sd0, 16'sd11586, 16'sd0);
    send_quat(16'sd11586, 16'sd0, -16'sd11586, 16'sd0);
    send_quat(16'sd11585, 16'sd11585, 16'sd0, 16'sd0);
    send_quat(16'sd11585, -16'sd11585, 16'sd0, 16'sd0);
    send_quat(16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192);
    send_quat(16'sd4096, 16'sd1000, -16'sd2000, -16'sd15000);
    send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_quat(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd1);
    send_quat(16'sd0, 16'sd0, 16'sd0, -16'sd1);
    send_quat(16'sd1, 16'sd1, 16'sd0, 16'sd0);
  endtask

  task automatic test_random(int n);
    logic signed [IN_W-1:0] w, x, y, z;
    repeat (n) begin
      rand_quat(w, x, y, z);
      send_quat(w, x, y, z);
    end
  endtask

  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    hold_req = 1'b1;
    test_random(120);
    tx_idle_en = 1'b1;
  endtask

  task automatic test_drain_pause();
    test_random(30);
    wait_drained();
    test_random(30);
  endtask

  // receiver side: random stalls and one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // result check: outputs are stable at the falling edge before the accepting edge
  initial begin
    euler_t e;
    forever begin
      @(negedge clk);
      if (!rst && out_valid && out_ready) begin
        recv_cnt++;
        if (angles_pending.size() == 0) begin
          $error("unexpected result: roll %0d pitch %0d yaw %0d",
                 roll_angle, pitch_angle, yaw_angle);
          err_cnt++;
        end else begin
          e = angles_pending.pop_front();
          if (roll_angle !== e.roll) begin
            $error("roll_angle: expected %0d, actual %0d", e.roll, roll_angle);
            err_cnt++;
          end
          if (pitch_angle !== e.pitch) begin
            $error("pitch_angle: expected %0d, actual %0d", e.pitch, pitch_angle);
            err_cnt++;
          end
          if (yaw_angle !== e.yaw) begin
            $error("yaw_angle: expected %0d, actual %0d", e.yaw, yaw_angle);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    set_unit(UNIT_DEG);
    test_directed();
    test_random(450);
    set_unit(UNIT_RAD);
    test_random(450);
    test_backpressure();
    test_drain_pause();
    set_unit(UNIT_DEG);
    // closing stretch without idling on either side
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random(350);
    wait_drained();
    if (angles_pending.size() != 0) err_cnt++;
    $display("covered %0d quaternions, %0d results, radian and degree units,",
             sent_cnt, recv_cnt);
    $display("gimbal clamp, zero atan2 operands, full-range noise and long output stalls");
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

endmodule
